### rtl/core/ils_pkg.sv
package ils_pkg;

  // fixed field widths of the request and response channels
  localparam int REQ_W    = 3;
  localparam int POS_W    = 9;
  localparam int VAL_W    = 32;
  localparam int STATUS_W = 2;
  localparam int RIDX_W   = 8;
  localparam int RCNT_W   = 9;

  // defaults for the top-level parameters
  localparam int CAPACITY_DEF   = 256;
  localparam int DATA_WIDTH_DEF = 32;

  typedef enum logic [REQ_W-1:0] {
    REQ_APPEND    = 3'd0,
    REQ_INSERT    = 3'd1,
    REQ_READ      = 3'd2,
    REQ_OVERWRITE = 3'd3,
    REQ_REMOVE    = 3'd4,
    REQ_CLEAR     = 3'd5
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK    = 2'd0,
    STS_RANGE = 2'd1,
    STS_FULL  = 2'd2
  } status_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic shift;
    logic commit;
    logic emit;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic shift_done;
    logic out_free;
  } dp_sts_t;

endpackage

### rtl/core/ils_req_if.sv
interface ils_req_if import ils_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [POS_W-1:0]  position;
  logic [VAL_W-1:0]  item_value;

  modport source (output valid, req_type, position, item_value, input ready);
  modport sink (input valid, req_type, position, item_value, output ready);
endinterface

### rtl/core/ils_rsp_if.sv
interface ils_rsp_if import ils_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [VAL_W-1:0]    read_value;
  logic [RIDX_W-1:0]   result_index;
  logic [RCNT_W-1:0]   item_count;
  logic                is_empty;

  modport source (output valid, status, read_value, result_index, item_count, is_empty,
                  input ready);
  modport sink (input valid, status, read_value, result_index, item_count, is_empty,
                output ready);
endinterface

### rtl/core/ils_ram.sv
module ils_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/ils_ctrl.sv
module ils_ctrl import ils_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SHIFT  = 4'b0010,
    S_COMMIT = 4'b0100,
    S_DONE   = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
        if (in_valid) begin
          state_nxt = S_SHIFT;
        end
      end
      S_SHIFT: begin
        cmd.shift = 1'b1;
        if (sts.shift_done) begin
          state_nxt = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        cmd.emit = sts.out_free;
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### rtl/core/ils_dp.sv
module ils_dp import ils_pkg::*; #(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  dp_cmd_t             cmd,
  output dp_sts_t             sts,
  input  logic [REQ_W-1:0]    in_req_type,
  input  logic [POS_W-1:0]    in_position,
  input  logic [VAL_W-1:0]    in_item_value,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] out_status,
  output logic [VAL_W-1:0]    out_read_value,
  output logic [RIDX_W-1:0]   out_result_index,
  output logic [RCNT_W-1:0]   out_item_count,
  output logic                out_is_empty
);

  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int IX_W   = (ADDR_W > RIDX_W) ? ADDR_W : RIDX_W;
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  // request registers
  req_t                  req_r;
  status_t               status_r;
  logic                  act_r;
  logic [ADDR_W-1:0]     pos_r;
  logic [ADDR_W-1:0]     idx_r;
  logic [DATA_WIDTH-1:0] val_r;
  logic                  rdsel_r;

  // list state and shift walker
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  left_r, left_nxt;
  logic [ADDR_W-1:0] ptr_r, ptr_nxt;
  logic [ADDR_W-1:0] wa_r, wa_nxt;
  logic              pend_r, pend_nxt;

  // response register
  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [VAL_W-1:0]    out_rd_r;
  logic [RIDX_W-1:0]   out_idx_r;
  logic [RCNT_W-1:0]   out_cnt_r;
  logic                out_empty_r;

  // request check
  req_t              req_in;
  logic [CMP_W-1:0]  pos_ext, cnt_ext, pos_p1;
  logic [CNT_W-1:0]  pos_cnt, cnt_m1;
  logic [63:0]       val_ext;
  status_t           chk_status;
  logic              chk_act;
  logic [CNT_W-1:0]  left_ld;
  logic [ADDR_W-1:0] ptr_ld;
  logic              full;

  // memory port
  logic                  ram_we, ram_re, issue;
  logic [ADDR_W-1:0]     ram_waddr, ram_raddr;
  logic [DATA_WIDTH-1:0] ram_wdata, ram_rdata;
  logic [63:0]           rd_ext;
  logic [IX_W-1:0]       idx_ext;
  logic [CMP_W-1:0]      cnt_out;

  assign req_in  = req_t'(in_req_type);
  assign pos_ext = CMP_W'(in_position);
  assign cnt_ext = CMP_W'(count_r);
  assign pos_p1  = pos_ext + 1'b1;
  assign pos_cnt = pos_ext[CNT_W-1:0];
  assign cnt_m1  = count_r - 1'b1;
  assign full    = (count_r == CAP_CNT);
  assign val_ext = 64'(in_item_value);

  always_comb begin
    chk_status = STS_OK;
    chk_act    = 1'b0;
    left_ld    = '0;
    ptr_ld     = '0;
    unique case (req_in)
      REQ_APPEND: begin
        if (full) begin
          chk_status = STS_FULL;
        end else begin
          chk_act = 1'b1;
        end
      end
      REQ_INSERT: begin
        priority if (pos_ext > cnt_ext) begin
          chk_status = STS_RANGE;
        end else if (full) begin
          chk_status = STS_FULL;
        end else begin
          chk_act = 1'b1;
          left_ld = count_r - pos_cnt;
          ptr_ld  = cnt_m1[ADDR_W-1:0];
        end
      end
      REQ_READ, REQ_OVERWRITE: begin
        if (pos_ext >= cnt_ext) begin
          chk_status = STS_RANGE;
        end else begin
          chk_act = 1'b1;
        end
      end
      REQ_REMOVE: begin
        if (pos_ext >= cnt_ext) begin
          chk_status = STS_RANGE;
        end else begin
          chk_act = 1'b1;
          left_ld = count_r - pos_cnt - 1'b1;
          ptr_ld  = pos_p1[ADDR_W-1:0];
        end
      end
      REQ_CLEAR: begin
        chk_act = 1'b1;
      end
      default: begin
        chk_act = 1'b0;
      end
    endcase
  end

  // shift walker: one read a cycle, each written back one place over in the next cycle
  assign issue = cmd.shift && (left_r != '0);

  always_comb begin
    left_nxt  = left_r;
    ptr_nxt   = ptr_r;
    wa_nxt    = wa_r;
    pend_nxt  = issue;
    count_nxt = count_r;
    if (cmd.load) begin
      left_nxt = left_ld;
      ptr_nxt  = ptr_ld;
    end else if (issue) begin
      left_nxt = left_r - 1'b1;
      if (req_r == REQ_INSERT) begin
        ptr_nxt = ptr_r - 1'b1;
        wa_nxt  = ptr_r + 1'b1;
      end else begin
        ptr_nxt = ptr_r + 1'b1;
        wa_nxt  = ptr_r - 1'b1;
      end
    end
    if (cmd.commit && act_r) begin
      unique case (req_r)
        REQ_APPEND, REQ_INSERT: count_nxt = count_r + 1'b1;
        REQ_REMOVE:             count_nxt = count_r - 1'b1;
        REQ_CLEAR:              count_nxt = '0;
        default:                count_nxt = count_r;
      endcase
    end
  end

  assign ram_re    = issue || (cmd.commit && act_r && (req_r == REQ_READ));
  assign ram_raddr = cmd.shift ? ptr_r : pos_r;
  assign ram_we    = pend_r || (cmd.commit && act_r &&
                     (req_r == REQ_APPEND || req_r == REQ_INSERT ||
                      req_r == REQ_OVERWRITE));
  assign ram_waddr = pend_r ? wa_r :
                     ((req_r == REQ_APPEND) ? count_r[ADDR_W-1:0] : pos_r);
  assign ram_wdata = pend_r ? ram_rdata : val_r;

  ils_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_ext  = 64'(ram_rdata);
  assign idx_ext = IX_W'(idx_r);
  assign cnt_out = CMP_W'(count_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      left_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      left_r  <= left_nxt;
      pend_r  <= pend_nxt;
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt;
    wa_r  <= wa_nxt;
    if (cmd.load) begin
      req_r    <= req_in;
      status_r <= chk_status;
      act_r    <= chk_act;
      pos_r    <= pos_ext[ADDR_W-1:0];
      val_r    <= val_ext[DATA_WIDTH-1:0];
      rdsel_r  <= chk_act && (req_in == REQ_READ);
      if (chk_act && req_in != REQ_CLEAR) begin
        idx_r <= (req_in == REQ_APPEND) ? count_r[ADDR_W-1:0] : pos_ext[ADDR_W-1:0];
      end else begin
        idx_r <= '0;
      end
    end
    if (cmd.emit) begin
      out_status_r <= status_r;
      out_rd_r     <= rdsel_r ? rd_ext[VAL_W-1:0] : '0;
      out_idx_r    <= idx_ext[RIDX_W-1:0];
      out_cnt_r    <= cnt_out[RCNT_W-1:0];
      out_empty_r  <= (count_r == '0);
    end
  end

  assign sts.shift_done = (left_r == '0) && !pend_r;
  assign sts.out_free   = !out_valid_r || out_ready;

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_read_value   = out_rd_r;
  assign out_result_index = out_idx_r;
  assign out_item_count   = out_cnt_r;
  assign out_is_empty     = out_empty_r;

endmodule

### rtl/core/indexed_list_store.sv
// indexed list store: an ordered list of up to CAPACITY words, addressed by
// position and kept dense from index 0. a request appends, inserts, reads,
// overwrites, removes or clears, and each gives exactly one response with a
// status, the word read, the index touched, the new count and an empty flag.
// the response is offered from a register once the request has gone
// through a shift walk, a commit and a hand-off; the walk moves n words:
// count - position for an insert, count - position - 1 for a remove, and
// none for the other requests. the store, with one read and one write
// port, moves one word per cycle through its registered read port, and
// the walk ends with the write-back of the last word moved. a new
// request is taken as soon as the previous one is handed to the response
// register, even if that response has not been taken yet. the store needs
// no clearing pass after reset; only entries below the count are ever read.
module indexed_list_store import ils_pkg::*; #(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  ils_req_if.sink   in_ch,
  ils_rsp_if.source out_ch
);

  // command and status between the sequencer and the datapath
  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequencer: idle, shift walk, commit, then hand off the response
  ils_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: range checks, count, store with its shift walker, response
  ils_dp #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_req_type      (in_ch.req_type),
    .in_position      (in_ch.position),
    .in_item_value    (in_ch.item_value),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_status       (out_ch.status),
    .out_read_value   (out_ch.read_value),
    .out_result_index (out_ch.result_index),
    .out_item_count   (out_ch.item_count),
    .out_is_empty     (out_ch.is_empty)
  );

`ifndef SYNTHESIS
  // the store must be settled before the final write or read of a request
  a_commit_after_shift: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> sts.shift_done)
    else $error("commit while the shift walk is still busy");

  // a response is never pushed over one that has not been taken
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> sts.out_free)
    else $error("response register overwritten");

  // only one request is in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("request accepted while another is in flight");

  // a transaction accepted always reaches the shift phase next
  a_load_starts_shift: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> cmd.shift)
    else $error("accepted request did not start its shift phase");
`endif

endmodule
